// ===== src/dram_rowhit_first_scheduler_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the DRAM row-hit-first scheduler core
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DRAM_ROWHIT_FIRST_SCHEDULER_CORE_MACROS_SVH
`define DRAM_ROWHIT_FIRST_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DRSCH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, checked outside reset.
`define DRSCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ===== src/drsch_pkg.sv =====
// ----------------------------------------------------------------------------
// DRAM row-hit-first scheduler package
// Widths, reset values, configuration register indexes and shared types.
// ----------------------------------------------------------------------------
package drsch_pkg;

  // Field widths.
  localparam int CountW = 7;
  localparam int MaskW  = 64;
  localparam int SlotW  = 6;
  localparam int TotalW = 32;
  localparam int WaitW  = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  // Default number of queue slots considered.
  localparam int QueueDepthDefault = 64;

  // Register reset values.
  localparam logic [CountW-1:0] HighWmReset    = 7'd40;
  localparam logic [CountW-1:0] LowWmReset     = 7'd20;
  localparam logic [WaitW-1:0]  WaitLimitReset = 3'd6;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgHighWm    = 2'd0,
    CfgLowWm     = 2'd1,
    CfgWaitLimit = 2'd2
  } cfg_idx_e;

  // Result of one slot pick.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [SlotW-1:0] slot;
  } pick_t;

endpackage

// ===== src/drsch_if.sv =====
// ----------------------------------------------------------------------------
// DRAM row-hit-first scheduler channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface drsch_req_if;
  logic                          valid;
  logic                          ready;
  logic [drsch_pkg::CountW-1:0]  read_count;
  logic [drsch_pkg::CountW-1:0]  write_count;
  logic [drsch_pkg::MaskW-1:0]   read_ready_mask;
  logic [drsch_pkg::MaskW-1:0]   read_hit_mask;
  logic [drsch_pkg::MaskW-1:0]   write_ready_mask;
  logic [drsch_pkg::MaskW-1:0]   write_hit_mask;

  modport source (output valid, read_count, write_count, read_ready_mask, read_hit_mask,
                  write_ready_mask, write_hit_mask, input ready);
  modport sink   (input valid, read_count, write_count, read_ready_mask, read_hit_mask,
                  write_ready_mask, write_hit_mask, output ready);
endinterface

interface drsch_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          issue_valid;
  logic                          issue_is_write;
  logic [drsch_pkg::SlotW-1:0]   issue_slot;
  logic                          issue_row_hit;
  logic                          drain_active;
  logic [drsch_pkg::TotalW-1:0]  row_hit_total;
  logic [drsch_pkg::TotalW-1:0]  read_after_wait_total;

  modport source (output valid, issue_valid, issue_is_write, issue_slot, issue_row_hit,
                  drain_active, row_hit_total, read_after_wait_total, input ready);
  modport sink   (input valid, issue_valid, issue_is_write, issue_slot, issue_row_hit,
                  drain_active, row_hit_total, read_after_wait_total, output ready);
endinterface

interface drsch_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [drsch_pkg::CfgIdxW-1:0]  index;
  logic [drsch_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/dram_rowhit_first_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// DRAM row-hit-first scheduler core
// Per-channel command picker with write drain hysteresis and statistics.
// ----------------------------------------------------------------------------
// One request is accepted per clock while the result side keeps up. The
// request is captured in the input register, the drain decision and the
// slot pick run in one pass of combinational logic, and the result lands
// in the output register once that register is free. The drain mode, idle
// wait counter and the two saturating totals update as each request leaves
// the input register.
// A full stream with the result side always ready therefore sustains one
// result per cycle. Only a stalled result channel slows the block down. The
// output register lets one more request enter while a finished result waits
// to be taken; after that the request side sees ready low until the result
// is taken.
module dram_rowhit_first_scheduler_core #(
  parameter int QueueDepth = drsch_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  drsch_req_if.sink   req,
  drsch_rsp_if.source rsp,
  drsch_cfg_if.sink   cfg
);
  import drsch_pkg::*;

  // Configuration registers.
  logic [CountW-1:0] high_wm_q, low_wm_q;
  logic [WaitW-1:0]  wait_limit_q;

  // Input stage.
  logic              s1_valid_q;
  logic [CountW-1:0] rc_q, wc_q;
  logic [MaskW-1:0]  rready_q, rhit_q, wready_q, whit_q;

  // Scheduler state.
  logic              drain_q, drain_d;
  logic [WaitW-1:0]  idle_q, idle_d;
  logic [TotalW-1:0] rh_total_q, rh_total_d;
  logic [TotalW-1:0] rw_total_q, rw_total_d;

  // Output stage.
  logic              out_valid_q;
  logic              out_issue_q, out_write_q, out_hit_q;
  logic [SlotW-1:0]  out_slot_q;

  logic              advance;
  logic [WaitW-1:0]  idle_step;
  logic [CountW-1:0] sel_count;
  logic [MaskW-1:0]  sel_ready, sel_hit;
  pick_t             pick;

  // Handshake: the input stage moves on when the output register is free.
  assign advance   = s1_valid_q && (!out_valid_q || rsp.ready);
  assign req.ready = !s1_valid_q || advance;
  assign cfg.ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_wm_q    <= HighWmReset;
      low_wm_q     <= LowWmReset;
      wait_limit_q <= WaitLimitReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CfgHighWm:    high_wm_q    <= cfg.data;
        CfgLowWm:     low_wm_q     <= cfg.data;
        CfgWaitLimit: wait_limit_q <= cfg.data[WaitW-1:0];
        default:      ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req.ready) begin
      s1_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      rc_q     <= req.read_count;
      wc_q     <= req.write_count;
      rready_q <= req.read_ready_mask;
      rhit_q   <= req.read_hit_mask;
      wready_q <= req.write_ready_mask;
      whit_q   <= req.write_hit_mask;
    end
  end

  // Drain mode with hysteresis, and the idle read wait counter.
  always_comb begin
    idle_step = idle_q;
    drain_d   = drain_q && (wc_q > low_wm_q);
    if (wc_q > high_wm_q) begin
      drain_d = 1'b1;
    end else begin
      if ((rc_q == '0) && (idle_q != '1)) begin
        idle_step = idle_q + WaitW'(1);
      end
      if (idle_step > wait_limit_q) begin
        idle_step = '0;
        drain_d   = 1'b1;
      end
    end
  end

  // Pick from the write queue in drain mode, else from the read queue.
  assign sel_count = drain_d ? wc_q     : rc_q;
  assign sel_ready = drain_d ? wready_q : rready_q;
  assign sel_hit   = drain_d ? whit_q   : rhit_q;

  drsch_picker #(
    .QueueDepth (QueueDepth)
  ) u_picker (
    .count_i (sel_count),
    .ready_i (sel_ready),
    .hit_i   (sel_hit),
    .pick_o  (pick)
  );

  // Statistics update, and the wait counter clears on a read issue.
  always_comb begin
    idle_d     = idle_step;
    rh_total_d = rh_total_q;
    rw_total_d = rw_total_q;
    if (pick.valid) begin
      if (pick.hit && (rh_total_q != '1)) begin
        rh_total_d = rh_total_q + TotalW'(1);
      end
      if (!drain_d) begin
        if ((idle_step != '0) && (rw_total_q != '1)) begin
          rw_total_d = rw_total_q + TotalW'(1);
        end
        idle_d = '0;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q    <= 1'b0;
      idle_q     <= '0;
      rh_total_q <= '0;
      rw_total_q <= '0;
    end else if (advance) begin
      drain_q    <= drain_d;
      idle_q     <= idle_d;
      rh_total_q <= rh_total_d;
      rw_total_q <= rw_total_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_issue_q <= pick.valid;
      out_write_q <= pick.valid & drain_d;
      out_hit_q   <= pick.valid & pick.hit;
      out_slot_q  <= pick.valid ? pick.slot : '0;
    end
  end

  assign rsp.valid                 = out_valid_q;
  assign rsp.issue_valid           = out_issue_q;
  assign rsp.issue_is_write        = out_write_q;
  assign rsp.issue_slot            = out_slot_q;
  assign rsp.issue_row_hit         = out_hit_q;
  assign rsp.drain_active          = drain_q;
  assign rsp.row_hit_total         = rh_total_q;
  assign rsp.read_after_wait_total = rw_total_q;

endmodule

// ===== src/drsch_picker.sv =====
// ----------------------------------------------------------------------------
// DRAM scheduler slot picker
// Finds the oldest issuable row hit, else the oldest issuable slot.
// ----------------------------------------------------------------------------
module drsch_picker #(
  parameter int QueueDepth = drsch_pkg::QueueDepthDefault
) (
  input  logic [drsch_pkg::CountW-1:0] count_i,
  input  logic [drsch_pkg::MaskW-1:0]  ready_i,
  input  logic [drsch_pkg::MaskW-1:0]  hit_i,
  output drsch_pkg::pick_t             pick_o
);
  import drsch_pkg::*;

  logic [CountW-1:0] limit;
  logic [MaskW-1:0]  elig;
  logic [MaskW-1:0]  hits;
  logic [MaskW-1:0]  cand;
  logic [MaskW-1:0]  lowest;
  logic [SlotW-1:0]  slot;

  // Only slots below the smaller of occupancy and depth take part.
  assign limit = (count_i > CountW'(QueueDepth)) ? CountW'(QueueDepth) : count_i;

  always_comb begin
    for (int i = 0; i < MaskW; i++) begin
      elig[i] = ready_i[i] & (CountW'(i) < limit);
    end
  end

  // Row hits win; otherwise any issuable slot.
  assign hits   = elig & hit_i;
  assign cand   = (|hits) ? hits : elig;
  assign lowest = cand & (~cand + MaskW'(1));

  // Encode the one-hot lowest candidate.
  always_comb begin
    slot = '0;
    for (int i = 0; i < MaskW; i++) begin
      if (lowest[i]) begin
        slot = slot | SlotW'(i);
      end
    end
  end

  assign pick_o.valid = |elig;
  assign pick_o.hit   = |hits;
  assign pick_o.slot  = slot;

endmodule

// ===== src/drsch_checker.sv =====
// ----------------------------------------------------------------------------
// DRAM row-hit-first scheduler port checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "dram_rowhit_first_scheduler_core_macros.svh"

module drsch_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic                          issue_valid_i,
  input logic                          issue_is_write_i,
  input logic [drsch_pkg::SlotW-1:0]   issue_slot_i,
  input logic                          issue_row_hit_i,
  input logic                          drain_active_i,
  input logic [drsch_pkg::TotalW-1:0]  row_hit_total_i
);

  // A stalled result stays offered.
  `DRSCH_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)

  // With no issue, the pick fields read as zero.
  `DRSCH_ASSERT_IMPL(a_no_pick_zero, clk_i, rst_ni, rsp_valid_i && !issue_valid_i, !issue_is_write_i && !issue_row_hit_i && (issue_slot_i == '0))

  // Writes are only picked in drain mode.
  `DRSCH_ASSERT_IMPL(a_write_in_drain, clk_i, rst_ni, rsp_valid_i && issue_is_write_i, drain_active_i)

  // A row-hit issue has been counted.
  `DRSCH_ASSERT_IMPL(a_hit_counted, clk_i, rst_ni, rsp_valid_i && issue_row_hit_i, row_hit_total_i != '0)

endmodule

bind dram_rowhit_first_scheduler_core drsch_checker u_drsch_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp.valid),
  .rsp_ready_i      (rsp.ready),
  .issue_valid_i    (rsp.issue_valid),
  .issue_is_write_i (rsp.issue_is_write),
  .issue_slot_i     (rsp.issue_slot),
  .issue_row_hit_i  (rsp.issue_row_hit),
  .drain_active_i   (rsp.drain_active),
  .row_hit_total_i  (rsp.row_hit_total)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the DRAM row-hit-first scheduler core
// Drives scheduling requests with random gaps and output stalls, mirrors the
// drain hysteresis, slot pick and statistics in a local predictor, and checks
// every result field against it across several threshold settings.
// ----------------------------------------------------------------------------
module tb;
  import drsch_pkg::*;

  localparam int QDepth      = QueueDepthDefault;
  localparam int RandPerSet  = 250;
  localparam int NumSettings = 6;
  localparam int HoldCycles  = 80;
  localparam int StallLimit  = 2000;

  // One scheduling request as driven on the request channel.
  typedef struct packed {
    logic [CountW-1:0] read_cnt;
    logic [CountW-1:0] write_cnt;
    logic [MaskW-1:0]  rd_ready;
    logic [MaskW-1:0]  rd_hit;
    logic [MaskW-1:0]  wr_ready;
    logic [MaskW-1:0]  wr_hit;
  } sched_req_t;

  // One scheduling decision as seen on the result channel.
  typedef struct packed {
    logic              valid;
    logic              is_write;
    logic [SlotW-1:0]  slot;
    logic              row_hit;
    logic              drain;
    logic [TotalW-1:0] hit_total;
    logic [TotalW-1:0] wait_read_total;
  } issue_t;

  // Directed row: a request and, where obvious, its typed-in decision.
  typedef struct packed {
    sched_req_t req;
    logic       typed;
    issue_t     want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  drsch_req_if req_if ();
  drsch_rsp_if rsp_if ();
  drsch_cfg_if cfg_if ();

  dram_rowhit_first_scheduler_core #(
    .QueueDepth(QDepth)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_if),
    .rsp   (rsp_if),
    .cfg   (cfg_if)
  );

  // Predictor state and its copy of the threshold registers.
  logic              drain_on;
  logic [WaitW-1:0]  idle_wait;
  logic [TotalW-1:0] hit_total;
  logic [TotalW-1:0] wait_read_total;
  logic [CountW-1:0] high_wm;
  logic [CountW-1:0] low_wm;
  logic [WaitW-1:0]  wait_lim;

  issue_t   pending_issues[$];
  dir_row_t dir_rows[$];

  int n_errors;
  int n_requests;
  int n_results;
  int n_writes;
  int n_hits;
  int n_no_pick;
  int n_drain;
  int quiet_cycles = 0;
  int req_gap_pct;
  int rsp_stall_pct;
  int hold_asked;
  int hold_served = 0;
  int hold_left = 0;
  int wc_walk;
  int zero_run;

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Lowest ready slot that is a row hit, else the lowest ready slot.
  function automatic void pick_slot(input int unsigned occupancy, input logic [MaskW-1:0] ready,
                                    input logic [MaskW-1:0] hit, output logic found,
                                    output logic [SlotW-1:0] slot, output logic is_hit);
    int unsigned lim;
    lim = (occupancy < QDepth) ? occupancy : QDepth;
    found = 1'b0;
    is_hit = 1'b0;
    slot = '0;
    for (int i = 0; i < lim; i++) begin
      if (ready[i]) begin
        if (hit[i]) begin
          if (!is_hit) begin
            slot = SlotW'(i);
            is_hit = 1'b1;
            found = 1'b1;
          end
        end else if (!found) begin
          found = 1'b1;
          slot = SlotW'(i);
        end
      end
    end
  endfunction

  // Advances the predictor by one request and returns the decision it makes.
  function automatic issue_t predict_issue(input sched_req_t r);
    issue_t res;
    logic found;
    logic is_hit;
    logic [SlotW-1:0] slot;
    res = '0;
    drain_on = drain_on && (r.write_cnt > low_wm);
    if (r.write_cnt > high_wm) begin
      drain_on = 1'b1;
    end else begin
      if (r.read_cnt == 0 && idle_wait != '1) idle_wait = idle_wait + 1'b1;
      if (idle_wait > wait_lim) begin
        idle_wait = '0;
        drain_on = 1'b1;
      end
    end
    if (drain_on) begin
      pick_slot(r.write_cnt, r.wr_ready, r.wr_hit, found, slot, is_hit);
    end else begin
      pick_slot(r.read_cnt, r.rd_ready, r.rd_hit, found, slot, is_hit);
    end
    if (found) begin
      res.valid = 1'b1;
      res.is_write = drain_on;
      res.slot = slot;
      res.row_hit = is_hit;
      if (is_hit && hit_total != '1) hit_total = hit_total + 1'b1;
      if (!drain_on) begin
        if (idle_wait != 0 && wait_read_total != '1) wait_read_total = wait_read_total + 1'b1;
        idle_wait = '0;
      end
    end
    res.drain = drain_on;
    res.hit_total = hit_total;
    res.wait_read_total = wait_read_total;
    return res;
  endfunction

  function automatic dir_row_t mk_row(input int rc, input int wc, input logic [MaskW-1:0] rr,
                                      input logic [MaskW-1:0] rh, input logic [MaskW-1:0] wr,
                                      input logic [MaskW-1:0] wh, input logic typed,
                                      input issue_t want);
    dir_row_t row;
    row.req.read_cnt = CountW'(rc);
    row.req.write_cnt = CountW'(wc);
    row.req.rd_ready = rr;
    row.req.rd_hit = rh;
    row.req.wr_ready = wr;
    row.req.wr_hit = wh;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic logic [MaskW-1:0] rand_mask();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      4: return {$urandom, $urandom} | {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random request: write occupancy wanders around the watermarks and the
  // read queue sometimes runs empty for a while to exercise the wait limit.
  function automatic sched_req_t random_req();
    sched_req_t r;
    wc_walk = wc_walk + int'($urandom_range(6)) - 3;
    if ($urandom_range(49) == 0) wc_walk = $urandom_range(127);
    if (wc_walk < 0) wc_walk = 0;
    if (wc_walk > 127) wc_walk = 127;
    if (zero_run > 0) begin
      zero_run--;
      r.read_cnt = '0;
    end else if ($urandom_range(19) == 0) begin
      zero_run = $urandom_range(9, 1);
      r.read_cnt = '0;
    end else if ($urandom_range(99) < 4) begin
      r.read_cnt = CountW'($urandom_range(127, 65));
    end else begin
      r.read_cnt = CountW'($urandom_range(64, 1));
    end
    r.write_cnt = CountW'(wc_walk);
    r.rd_ready = rand_mask();
    r.rd_hit = rand_mask();
    r.wr_ready = rand_mask();
    r.wr_hit = rand_mask();
    return r;
  endfunction

  // Offers one request, records its expected decision when it is taken, and
  // then idles the request channel at random.
  task automatic offer_request(input sched_req_t r, input logic typed, input issue_t want);
    issue_t predicted;
    req_if.valid <= 1'b1;
    req_if.read_count <= r.read_cnt;
    req_if.write_count <= r.write_cnt;
    req_if.read_ready_mask <= r.rd_ready;
    req_if.read_hit_mask <= r.rd_hit;
    req_if.write_ready_mask <= r.wr_ready;
    req_if.write_hit_mask <= r.wr_hit;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = predict_issue(r);
    pending_issues.push_back(typed ? want : predicted);
    n_requests++;
    if ($urandom_range(99) < req_gap_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < req_gap_pct);
    end
  endtask

  // Lowers the request valid and waits until every decision has come back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_issues.size() != 0);
  endtask

  // Writes all three threshold registers back to back.
  task automatic write_thresholds(input int high, input int low, input int wlim);
    cfg_idx_e idx[3];
    int val[3];
    idx = '{CfgHighWm, CfgLowWm, CfgWaitLimit};
    val = '{high, low, wlim};
    for (int i = 0; i < 3; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data <= CfgDataW'(val[i]);
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      case (idx[i])
        CfgHighWm:    high_wm = CountW'(val[i]);
        CfgLowWm:     low_wm = CountW'(val[i]);
        CfgWaitLimit: wait_lim = WaitW'(val[i]);
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        req_gap_pct = 37;
        rsp_stall_pct <= 52;
      end
      1: begin
        req_gap_pct = 52;
        rsp_stall_pct <= 37;
      end
      default: begin
        req_gap_pct = 0;
        rsp_stall_pct <= 0;
      end
    endcase
  endtask

  function automatic void check_field(input string name, input logic [TotalW-1:0] want,
                                      input logic [TotalW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // Result side: random stalls, plus a long hold-off when one is asked for.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      rsp_if.ready <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left <= HoldCycles;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Compare each returned decision with the oldest outstanding one.
  always @(posedge clk_i) begin : check_result
    issue_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_issues.size() == 0) begin
        $display("%0t: result returned with no request outstanding", $time);
        n_errors++;
      end else begin
        want = pending_issues.pop_front();
        check_field("issue_valid", want.valid, rsp_if.issue_valid);
        check_field("issue_is_write", want.is_write, rsp_if.issue_is_write);
        check_field("issue_slot", want.slot, rsp_if.issue_slot);
        check_field("issue_row_hit", want.row_hit, rsp_if.issue_row_hit);
        check_field("drain_active", want.drain, rsp_if.drain_active);
        check_field("row_hit_total", want.hit_total, rsp_if.row_hit_total);
        check_field("read_after_wait_total", want.wait_read_total,
                    rsp_if.read_after_wait_total);
        n_results++;
        if (!want.valid) n_no_pick++;
        if (want.is_write) n_writes++;
        if (want.row_hit) n_hits++;
        if (want.drain) n_drain++;
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("%0t: no handshake for %0d cycles", $time, StallLimit);
    $display("FAIL dram_rowhit_first_scheduler_core");
    $finish;
  end

  // Main stimulus.
  initial begin
    int set_high[NumSettings];
    int set_low[NumSettings];
    int set_wait[NumSettings];
    set_high = '{40, 0, 127, 64, 10, 48};
    set_low = '{20, 0, 127, 0, 30, 16};
    set_wait = '{6, 0, 7, 3, 1, 5};
    n_errors = 0;
    n_requests = 0;
    n_results = 0;
    n_writes = 0;
    n_hits = 0;
    n_no_pick = 0;
    n_drain = 0;
    hold_asked = 0;
    wc_walk = 20;
    zero_run = 0;
    drain_on = 1'b0;
    idle_wait = '0;
    hit_total = '0;
    wait_read_total = '0;
    high_wm = HighWmReset;
    low_wm = LowWmReset;
    wait_lim = WaitLimitReset;
    req_gap_pct = 0;
    rsp_stall_pct = 0;
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.read_count <= '0;
    req_if.write_count <= '0;
    req_if.read_ready_mask <= '0;
    req_if.read_hit_mask <= '0;
    req_if.write_ready_mask <= '0;
    req_if.write_hit_mask <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CfgHighWm;
    cfg_if.data <= '0;

    // Directed rows. Decisions are typed in for the first few after reset.
    dir_rows.push_back(mk_row(1, 0, 64'd1, 64'd1, '0, '0, 1'b1,
                              '{1'b1, 1'b0, 6'd0, 1'b1, 1'b0, 32'd1, 32'd0}));
    // Empty read queue: nothing to pick, idle wait starts counting.
    dir_rows.push_back(mk_row(0, 0, '1, '1, '1, '1, 1'b1,
                              '{1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 32'd1, 32'd0}));
    // Last slot of a full read queue, issued after a wait.
    dir_rows.push_back(mk_row(64, 0, 64'h8000_0000_0000_0000, '0, '0, '0, 1'b1,
                              '{1'b1, 1'b0, 6'd63, 1'b0, 1'b0, 32'd1, 32'd1}));
    // Write count at its maximum forces drain; no write is ready.
    dir_rows.push_back(mk_row(127, 127, '1, 64'h8000_0000_0000_0000, '0, '1, 1'b1,
                              '{1'b0, 1'b0, 6'd0, 1'b0, 1'b1, 32'd1, 32'd1}));
    // Drain holds above the low mark; the hit bit beyond occupancy is ignored.
    dir_rows.push_back(mk_row(127, 21, '1, '1, '1, 64'h8000_0000_0000_0000, 1'b1,
                              '{1'b1, 1'b1, 6'd0, 1'b0, 1'b1, 32'd1, 32'd1}));
    // Drain ends at the low mark; hit preferred, slot above occupancy ignored.
    dir_rows.push_back(mk_row(3, 20, 64'h24, 64'h26, '1, '1, 1'b1,
                              '{1'b1, 1'b0, 6'd2, 1'b1, 1'b0, 32'd2, 32'd1}));
    // Seven requests with no reads force drain through the wait limit.
    for (int i = 0; i < 7; i++) dir_rows.push_back(mk_row(0, 0, '1, '1, '1, '1, 1'b0, '0));
    dir_rows.push_back(mk_row(5, 30, '1, '0, 64'h0F0, 64'h0C0, 1'b0, '0));
    dir_rows.push_back(mk_row(0, 41, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(65, 0, '1, 64'h8000_0000_0000_0000, '0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(0, 0, '1, '0, '0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(2, 0, 64'h2, '0, '0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(64, 64, '1, '1, '1, '1, 1'b0, '0));
    dir_rows.push_back(mk_row(64, 64, '1, '0, '0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(0, 0, '0, '0, '0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(127, 0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                              '1, '1, 1'b0, '0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0);
    foreach (dir_rows[i]) offer_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // Random part, one block per threshold setting.
    for (int s = 0; s < NumSettings; s++) begin
      drain_results();
      if (s != 0) write_thresholds(set_high[s], set_low[s], set_wait[s]);
      set_idling(s / 2);
      for (int i = 0; i < RandPerSet; i++) begin
        if (i == RandPerSet / 2 && (s == 0 || s == 4)) hold_asked <= hold_asked + 1;
        if (i == RandPerSet / 2 && s == 2) drain_results();
        offer_request(random_req(), 1'b0, '0);
      end
    end
    drain_results();
    repeat (10) @(posedge clk_i);

    $display("Checked %0d decisions for %0d requests over %0d threshold settings.",
             n_results, n_requests, NumSettings);
    $display("Seen: %0d write issues, %0d row hits, %0d with no pick, %0d in drain mode.",
             n_writes, n_hits, n_no_pick, n_drain);
    if (n_errors == 0 && pending_issues.size() == 0) begin
      $display("PASS dram_rowhit_first_scheduler_core");
    end else begin
      $display("FAIL dram_rowhit_first_scheduler_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/drsch_pkg.sv
src/drsch_if.sv
src/drsch_picker.sv
src/dram_rowhit_first_scheduler_core.sv
src/drsch_checker.sv
tb/tb.sv
